@@ hw/rtl/scd_pkg.sv @@
// scd_pkg: shared types, scancode constants and key translation tables
// for the scancode decoder; no dependencies
package scd_pkg;

  localparam int TABLE_ENTRIES = 84;

  localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
  localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] KEY_C_MAKE   = 8'h2E;
  localparam logic [6:0] KEY_UP       = 7'h48;
  localparam logic [6:0] KEY_DOWN     = 7'h50;
  localparam logic [6:0] KEY_LEFT     = 7'h4B;
  localparam logic [6:0] KEY_RIGHT    = 7'h4D;

  typedef enum logic [2:0] {
    ARROW_NONE  = 3'd0,
    ARROW_UP    = 3'd1,
    ARROW_DOWN  = 3'd2,
    ARROW_LEFT  = 3'd3,
    ARROW_RIGHT = 3'd4
  } arrow_e;

  typedef struct packed {
    logic prefix;
    logic ctrl;
    logic caps;
    logic shift;
  } flags_t;

  typedef struct packed {
    logic       ctrl_held;
    logic       caps_active;
    logic       shift_held;
    logic       interrupt_request;
    logic [6:0] ascii_char;
    logic [2:0] arrow_code;
    logic       extended;
    logic       released;
    logic [6:0] key_number;
  } event_t;

  function automatic logic [6:0] plain_char(input logic [6:0] key);
    logic [6:0] c;
    case (key)
      7'd1:  c = 7'h01;  7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;  7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;  7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;  7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h71;
      7'd17: c = 7'h77;  7'd18: c = 7'h65;  7'd19: c = 7'h72;  7'd20: c = 7'h74;
      7'd21: c = 7'h79;  7'd22: c = 7'h75;  7'd23: c = 7'h69;  7'd24: c = 7'h6F;
      7'd25: c = 7'h70;  7'd26: c = 7'h5B;  7'd27: c = 7'h5D;  7'd28: c = 7'h0A;
      7'd30: c = 7'h61;  7'd31: c = 7'h73;  7'd32: c = 7'h64;  7'd33: c = 7'h66;
      7'd34: c = 7'h67;  7'd35: c = 7'h68;  7'd36: c = 7'h6A;  7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;  7'd39: c = 7'h3B;  7'd40: c = 7'h27;  7'd41: c = 7'h60;
      7'd43: c = 7'h5C;  7'd44: c = 7'h7A;  7'd45: c = 7'h78;  7'd46: c = 7'h63;
      7'd47: c = 7'h76;  7'd48: c = 7'h62;  7'd49: c = 7'h6E;  7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;  7'd52: c = 7'h2E;  7'd53: c = 7'h2F;  7'd55: c = 7'h2A;
      7'd57: c = 7'h20;  7'd71: c = 7'h37;  7'd72: c = 7'h38;  7'd73: c = 7'h39;
      7'd74: c = 7'h2D;  7'd75: c = 7'h34;  7'd76: c = 7'h35;  7'd77: c = 7'h36;
      7'd78: c = 7'h2B;  7'd79: c = 7'h31;  7'd80: c = 7'h32;  7'd81: c = 7'h33;
      7'd82: c = 7'h30;  7'd83: c = 7'h2E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [6:0] key);
    logic [6:0] c;
    case (key)
      7'd1:  c = 7'h01;  7'd2:  c = 7'h21;  7'd3:  c = 7'h40;  7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;  7'd6:  c = 7'h25;  7'd7:  c = 7'h5E;  7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A;  7'd10: c = 7'h28;  7'd11: c = 7'h29;  7'd12: c = 7'h5F;
      7'd13: c = 7'h2B;  7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h51;
      7'd17: c = 7'h57;  7'd18: c = 7'h45;  7'd19: c = 7'h52;  7'd20: c = 7'h54;
      7'd21: c = 7'h59;  7'd22: c = 7'h55;  7'd23: c = 7'h49;  7'd24: c = 7'h4F;
      7'd25: c = 7'h50;  7'd26: c = 7'h7B;  7'd27: c = 7'h7D;  7'd28: c = 7'h0A;
      7'd30: c = 7'h41;  7'd31: c = 7'h53;  7'd32: c = 7'h44;  7'd33: c = 7'h46;
      7'd34: c = 7'h47;  7'd35: c = 7'h48;  7'd36: c = 7'h4A;  7'd37: c = 7'h4B;
      7'd38: c = 7'h4C;  7'd39: c = 7'h3A;  7'd40: c = 7'h22;  7'd41: c = 7'h7E;
      7'd43: c = 7'h7C;  7'd44: c = 7'h5A;  7'd45: c = 7'h58;  7'd46: c = 7'h43;
      7'd47: c = 7'h56;  7'd48: c = 7'h42;  7'd49: c = 7'h4E;  7'd50: c = 7'h4D;
      7'd51: c = 7'h3C;  7'd52: c = 7'h3E;  7'd53: c = 7'h3F;  7'd55: c = 7'h2A;
      7'd57: c = 7'h20;  7'd71: c = 7'h37;  7'd72: c = 7'h38;  7'd73: c = 7'h39;
      7'd74: c = 7'h2D;  7'd75: c = 7'h34;  7'd76: c = 7'h35;  7'd77: c = 7'h36;
      7'd78: c = 7'h2B;  7'd79: c = 7'h31;  7'd80: c = 7'h32;  7'd81: c = 7'h33;
      7'd82: c = 7'h30;  7'd83: c = 7'h2E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/scd_flag_mem.sv @@
// scd_flag_mem: one-entry synchronous flag memory with registered read,
// reset-valid bit and write forwarding; depends on scd_pkg
module scd_flag_mem (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  scd_pkg::flags_t wdata_i,
  output scd_pkg::flags_t rdata_o
);
  import scd_pkg::*;

  flags_t mem_q [1];
  flags_t rd_q;
  flags_t fwd_q;
  logic   valid_q;
  logic   rd_valid_q;
  logic   fwd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[0] <= wdata_i;
    end
    rd_q  <= mem_q[0];
    fwd_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      rd_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q <= 1'b1;
      end
      rd_valid_q  <= valid_q;
      fwd_valid_q <= we_i;
    end
  end

  // read data lags one write; bypass the word written last cycle
  always_comb begin
    if (fwd_valid_q) begin
      rdata_o = fwd_q;
    end else if (rd_valid_q) begin
      rdata_o = rd_q;
    end else begin
      rdata_o = '0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |=> rdata_o == $past(wdata_i))
    else $error("flag memory read does not return last write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> valid_q)
    else $error("read valid without written entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> (rdata_o == '0 || fwd_valid_q))
    else $error("unwritten entry reads nonzero");

endmodule

@@ hw/rtl/scd_key_xlat.sv @@
// scd_key_xlat: modifier update and key event translation for one byte
// depends on scd_pkg tables and types
module scd_key_xlat (
  input  logic [7:0]      byte_i,
  input  scd_pkg::flags_t flags_i,
  output scd_pkg::flags_t flags_o,
  output scd_pkg::event_t event_o,
  output logic            has_result_o
);
  import scd_pkg::*;

  logic [6:0] key;
  arrow_e     arrow;
  logic [6:0] ch;
  flags_t     f;

  assign key = byte_i[6:0];

  always_comb begin
    f = flags_i;
    if (byte_i == PREFIX_BYTE) begin
      f.prefix = 1'b1;
    end else begin
      if (byte_i == LSHIFT_MAKE || byte_i == RSHIFT_MAKE) begin
        f.shift = 1'b1;
      end
      if (byte_i == LSHIFT_BREAK || byte_i == RSHIFT_BREAK) begin
        f.shift = 1'b0;
      end
      if (byte_i == CTRL_MAKE) begin
        f.ctrl = 1'b1;
      end
      if (byte_i == CTRL_BREAK) begin
        f.ctrl = 1'b0;
      end
      if (byte_i == CAPS_MAKE) begin
        f.caps = ~f.caps;
      end
      f.prefix = 1'b0;
    end
  end

  always_comb begin
    arrow = ARROW_NONE;
    if (flags_i.prefix) begin
      case (key)
        KEY_UP:    arrow = ARROW_UP;
        KEY_DOWN:  arrow = ARROW_DOWN;
        KEY_LEFT:  arrow = ARROW_LEFT;
        KEY_RIGHT: arrow = ARROW_RIGHT;
        default:   arrow = ARROW_NONE;
      endcase
    end
  end

  always_comb begin
    ch = 7'h00;
    if (arrow == ARROW_NONE && int'(key) < TABLE_ENTRIES && shifted_char(key) != 7'h00) begin
      ch = (f.shift ^ f.caps) ? shifted_char(key) : plain_char(key);
    end
  end

  assign flags_o      = f;
  assign has_result_o = (byte_i != PREFIX_BYTE);

  always_comb begin
    event_o.key_number        = key;
    event_o.released          = byte_i[7];
    event_o.extended          = flags_i.prefix;
    event_o.arrow_code        = arrow;
    event_o.ascii_char        = ch;
    event_o.interrupt_request = (byte_i == KEY_C_MAKE) && f.ctrl;
    event_o.shift_held        = f.shift;
    event_o.caps_active       = f.caps;
    event_o.ctrl_held         = f.ctrl;
  end

endmodule

@@ hw/rtl/scancode_to_ascii_decoder_core.sv @@
// scancode_to_ascii_decoder_core: scancode set 1 byte stream to key events
// pipeline: byte held in s1_byte_q, then its event word in out_event_q
// throughput: one byte per cycle unless stalled, set by the flag memory RMW loop
// reset: asynchronous active low; clears pipeline valids and the flag memory
// valid bit, so shift, caps, ctrl and prefix read as zero afterwards
// depends on scd_pkg, scd_flag_mem, scd_key_xlat
module scancode_to_ascii_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // scan_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // key_number[6:0] released[7] extended[8] arrow_code[11:9] ascii_char[18:12]
  // interrupt_request[19] shift_held[20] caps_active[21] ctrl_held[22] zero[23]
  output logic [23:0] m_axis_tdata
);
  import scd_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_adv;
  logic       s1_fire;
  logic       out_valid_q;
  event_t     out_event_q;
  flags_t     flags_cur;
  flags_t     flags_nxt;
  event_t     ev;
  logic       has_result;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && s1_adv;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  scd_flag_mem u_flag_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_fire),
    .wdata_i (flags_nxt),
    .rdata_o (flags_cur)
  );

  scd_key_xlat u_key_xlat (
    .byte_i       (s1_byte_q),
    .flags_i      (flags_cur),
    .flags_o      (flags_nxt),
    .event_o      (ev),
    .has_result_o (has_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && has_result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_byte_q <= s_axis_tdata;
    end
    if (s1_fire && has_result) begin
      out_event_q <= ev;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_event_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_byte_q == PREFIX_BYTE) |=> !m_axis_tvalid)
    else $error("prefix byte produced a word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_byte_q == LSHIFT_MAKE || s1_byte_q == RSHIFT_MAKE))
      |=> (m_axis_tvalid && m_axis_tdata[20]))
    else $error("shift make not reflected in word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:9] == 3'd0 || m_axis_tdata[18:12] == 7'd0))
    else $error("arrow and character both set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> flags_cur == $past(flags_nxt))
    else $error("flag update lost between back-to-back bytes");

endmodule
